// File: sv/movdec_pkg.sv
// shared types, codes and decode helpers for the mov byte decoder
package movdec_pkg;

  localparam logic [7:0] OP_REGMEM_VAL = 8'b1000_1000;
  localparam logic [7:0] OP_REGMEM_MSK = 8'b1111_1100;
  localparam logic [7:0] OP_IMM_VAL    = 8'b1011_0000;
  localparam logic [7:0] OP_IMM_MSK    = 8'b1111_0000;
  localparam logic [2:0] RM_DIRECT     = 3'b110;
  localparam logic [7:0] SIGN_BIT8     = 8'b1000_0000;
  localparam logic [15:0] SEXT_HIGH    = 16'b1111_1111_0000_0000;

  typedef enum logic [2:0] {
    PH_OPCODE  = 3'd0,
    PH_MODRM   = 3'd1,
    PH_DISP_LO = 3'd2,
    PH_DISP_HI = 3'd3,
    PH_DATA_LO = 3'd4,
    PH_DATA_HI = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    KIND_REGMEM  = 2'd0,
    KIND_IMM     = 2'd1,
    KIND_UNKNOWN = 2'd2
  } kind_t;

  typedef struct packed {
    phase_t     phase;
    logic [7:0] held_opcode;
    logic [7:0] held_modrm;
    logic [7:0] held_low_byte;
  } dec_state_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  first_byte;
    logic        direction;
    logic        wide;
    logic [1:0]  mode;
    logic [2:0]  reg_code;
    logic [2:0]  rm_code;
    logic        direct_address;
    logic [1:0]  disp_size;
    logic [15:0] displacement;
    logic [15:0] immediate;
    logic [2:0]  length;
  } dec_result_t;

  function automatic logic [1:0] disp_need(input logic [7:0] modrm);
    logic [1:0] need;
    need = 2'd0;
    if (modrm[7:6] == 2'd1) begin
      need = 2'd1;
    end else if (modrm[7:6] == 2'd2) begin
      need = 2'd2;
    end else if (modrm[7:6] == 2'd0 && modrm[2:0] == RM_DIRECT) begin
      need = 2'd2;
    end
    return need;
  endfunction

  function automatic logic [15:0] sext8(input logic [7:0] b);
    return ((b & SIGN_BIT8) != 8'd0) ? (SEXT_HIGH | {8'd0, b}) : {8'd0, b};
  endfunction

  function automatic dec_result_t make_regmem(input logic [7:0] opcode,
                                              input logic [7:0] modrm,
                                              input logic [1:0] dsize,
                                              input logic [15:0] disp,
                                              input logic [2:0] len);
    dec_result_t r;
    r = '0;
    r.kind           = KIND_REGMEM;
    r.first_byte     = opcode;
    r.direction      = opcode[1];
    r.wide           = opcode[0];
    r.mode           = modrm[7:6];
    r.reg_code       = modrm[5:3];
    r.rm_code        = modrm[2:0];
    r.direct_address = (modrm[7:6] == 2'd0) && (modrm[2:0] == RM_DIRECT);
    r.disp_size      = dsize;
    r.displacement   = disp;
    r.length         = len;
    return r;
  endfunction

  function automatic dec_result_t make_imm(input logic [7:0] opcode,
                                           input logic [15:0] imm,
                                           input logic [2:0] len);
    dec_result_t r;
    r = '0;
    r.kind      = KIND_IMM;
    r.first_byte = opcode;
    r.wide      = opcode[3];
    r.reg_code  = opcode[2:0];
    r.immediate = imm;
    r.length    = len;
    return r;
  endfunction

endpackage

// File: sv/movdec_step.sv
// next-state and result logic for one instruction byte
module movdec_step import movdec_pkg::*; (
  input  dec_state_t  cur,
  input  logic [7:0]  code_byte,
  output dec_state_t  nxt,
  output logic        emit,
  output dec_result_t result
);

  always_comb begin
    nxt    = cur;
    emit   = 1'b0;
    result = '0;
    unique case (cur.phase)
      PH_MODRM: begin
        nxt.held_modrm = code_byte;
        if (disp_need(code_byte) == 2'd0) begin
          emit      = 1'b1;
          result    = make_regmem(cur.held_opcode, code_byte, 2'd0, 16'd0, 3'd2);
          nxt.phase = PH_OPCODE;
        end else begin
          nxt.phase = PH_DISP_LO;
        end
      end
      PH_DISP_LO: begin
        if (disp_need(cur.held_modrm) == 2'd1) begin
          emit      = 1'b1;
          result    = make_regmem(cur.held_opcode, cur.held_modrm, 2'd1,
                                  sext8(code_byte), 3'd3);
          nxt.phase = PH_OPCODE;
        end else begin
          nxt.held_low_byte = code_byte;
          nxt.phase         = PH_DISP_HI;
        end
      end
      PH_DISP_HI: begin
        emit      = 1'b1;
        result    = make_regmem(cur.held_opcode, cur.held_modrm, 2'd2,
                                {code_byte, cur.held_low_byte}, 3'd4);
        nxt.phase = PH_OPCODE;
      end
      PH_DATA_LO: begin
        if (!cur.held_opcode[3]) begin
          emit      = 1'b1;
          result    = make_imm(cur.held_opcode, sext8(code_byte), 3'd2);
          nxt.phase = PH_OPCODE;
        end else begin
          nxt.held_low_byte = code_byte;
          nxt.phase         = PH_DATA_HI;
        end
      end
      PH_DATA_HI: begin
        emit      = 1'b1;
        result    = make_imm(cur.held_opcode, {code_byte, cur.held_low_byte}, 3'd3);
        nxt.phase = PH_OPCODE;
      end
      default: begin
        // opcode phase, and any unreachable phase code
        nxt.held_opcode = code_byte;
        if ((code_byte & OP_REGMEM_MSK) == OP_REGMEM_VAL) begin
          nxt.phase = PH_MODRM;
        end else if ((code_byte & OP_IMM_MSK) == OP_IMM_VAL) begin
          nxt.phase = PH_DATA_LO;
        end else begin
          emit              = 1'b1;
          result            = '0;
          result.kind       = KIND_UNKNOWN;
          result.first_byte = code_byte;
          result.length     = 3'd1;
          nxt.phase         = PH_OPCODE;
        end
      end
    endcase
  end

endmodule

// File: sv/movdec_out.sv
// result register with a skid stage
module movdec_out import movdec_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  dec_result_t push_data,
  input  logic        out_stall,
  output logic        out_valid,
  output dec_result_t out_data,
  output logic        skid_valid
);

  dec_result_t skid_data;
  logic        take;

  assign take = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (skid_valid) begin
        if (take) begin
          out_valid  <= 1'b1;
          out_data   <= skid_data;
          skid_valid <= 1'b0;
        end
      end else if (push) begin
        if (out_valid && out_stall) begin
          skid_valid <= 1'b1;
          skid_data  <= push_data;
        end else begin
          out_valid <= 1'b1;
          out_data  <= push_data;
        end
      end else if (take) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// File: sv/mov_instruction_byte_decoder.sv
// top level of the byte-serial mov instruction decoder
//
// input channel: one instruction byte per item on code_byte, in_valid/in_stall.
// output channel: one decoded instruction per item, out_valid/out_stall, with
//   kind, opcode, d/w bits, modrm fields, displacement, immediate and length.
// the decoder keeps the partial instruction (opcode, modrm, low byte, phase)
//   and emits a result on the byte that completes a register/memory mov or an
//   immediate-to-register mov; a byte that starts neither gives an unknown
//   result at once. bytes after the opcode are always taken as operand data.
// the last byte of an instruction pushes its result into the result register,
//   or into the skid stage while the receiver stalls. one byte per cycle is
//   taken while in_stall is low, through the combinational phase update.
// when the receiver stalls, the pending result holds and one more result can
//   land in the skid stage; in_stall rises only while that stage is full.
// reset (synchronous, active high) returns to the opcode phase, clears the
//   held bytes and empties both output stages.
module mov_instruction_byte_decoder import movdec_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         code_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         kind,
  output logic [7:0]         first_byte,
  output logic               direction,
  output logic               wide,
  output logic [1:0]         mode,
  output logic [2:0]         reg_code,
  output logic [2:0]         rm_code,
  output logic               direct_address,
  output logic [1:0]         disp_size,
  output logic signed [15:0] displacement,
  output logic signed [15:0] immediate,
  output logic [2:0]         length
);

  // decode state of the instruction in flight
  dec_state_t  state;
  dec_state_t  state_next;
  logic        emit;
  dec_result_t step_result;
  dec_result_t res;
  logic        skid_valid;
  logic        accept;

  // a byte is taken whenever the skid stage has room
  assign in_stall = skid_valid;
  assign accept   = in_valid && !in_stall;

  movdec_step u_step (
    .cur       (state),
    .code_byte (code_byte),
    .nxt       (state_next),
    .emit      (emit),
    .result    (step_result)
  );

  // state advances only on accepted bytes
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '{phase: PH_OPCODE, held_opcode: 8'd0, held_modrm: 8'd0,
                 held_low_byte: 8'd0};
    end else if (accept) begin
      state <= state_next;
    end
  end

  movdec_out u_out (
    .clk        (clk),
    .rst        (rst),
    .push       (accept && emit),
    .push_data  (step_result),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .out_data   (res),
    .skid_valid (skid_valid)
  );

  // unpack the result register onto the ports
  assign kind           = res.kind;
  assign first_byte     = res.first_byte;
  assign direction      = res.direction;
  assign wide           = res.wide;
  assign mode           = res.mode;
  assign reg_code       = res.reg_code;
  assign rm_code        = res.rm_code;
  assign direct_address = res.direct_address;
  assign disp_size      = res.disp_size;
  assign displacement   = $signed(res.displacement);
  assign immediate      = $signed(res.immediate);
  assign length         = res.length;

  // the skid stage only fills behind a held result
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid stage full with empty result register");

  // last displacement byte always produces a result
  a_disp_hi_emits: assert property (@(posedge clk) disable iff (rst)
    (accept && state.phase == PH_DISP_HI) |=> out_valid)
    else $error("no result after final displacement byte");

  // unknown bytes are single-byte results
  a_unknown_len: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind == KIND_UNKNOWN) |-> (length == 3'd1 && disp_size == 2'd0))
    else $error("unknown result with bad length");

  // register/memory results carry no immediate
  a_regmem_no_imm: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind == KIND_REGMEM) |-> (immediate == 16'sd0 && disp_size != 2'd3))
    else $error("malformed register/memory result");

endmodule
